// File: hdl/per_process_descriptor_table_defines.svh
// Assertion macros shared by the descriptor table checker.
`ifndef PER_PROCESS_DESCRIPTOR_TABLE_DEFINES_SVH
`define PER_PROCESS_DESCRIPTOR_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPDT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ppdt_pkg.sv
// Package: sizes, codes, types and helpers of the descriptor table.
package ppdt_pkg;

  localparam int NUM_PROCESSES   = 8;
  localparam int FDS_PER_PROCESS = 16;
  localparam int TABLE_DEPTH     = NUM_PROCESSES * FDS_PER_PROCESS;

  // Index widths (at least one bit each)
  localparam int PW  = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
  localparam int FW  = (FDS_PER_PROCESS > 1) ? $clog2(FDS_PER_PROCESS) : 1;
  localparam int TW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  // Scan counter must hold the larger entry count itself
  localparam int SCW = ((PW > FW) ? PW : FW) + 1;

  // Fixed field widths
  localparam int PID_W    = 15;
  localparam int OBJ_W    = 10;
  localparam int ACCESS_W = 9;
  localparam int MODE_W   = 2;
  localparam int FDNUM_W  = 8;
  localparam int DOUT_W   = 4;

  // Access right bit positions
  localparam int RD_BIT = 8;
  localparam int WR_BIT = 7;

  typedef enum logic {
    CMD_OPEN  = 1'b0,
    CMD_CLOSE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_RD   = 2'd0,
    MODE_WR   = 2'd1,
    MODE_RDWR = 2'd2,
    MODE_BAD  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_DENIED       = 3'd1,
    ST_ALREADY_OPEN = 3'd2,
    ST_NO_SLOT      = 3'd3,
    ST_UNKNOWN_PROC = 3'd4,
    ST_BAD_FD       = 3'd5,
    ST_FD_CLOSED    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PSCAN,
    S_DSCAN,
    S_DONE
  } state_t;

  // Mode versus object rights
  function automatic logic permitted(logic [MODE_W-1:0] mode, logic [ACCESS_W-1:0] bits);
    logic ok;
    ok = 1'b0;
    unique case (mode)
      MODE_RD:   ok = bits[RD_BIT];
      MODE_WR:   ok = bits[WR_BIT];
      MODE_RDWR: ok = bits[RD_BIT] & bits[WR_BIT];
      default:   ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Flat descriptor table address of (slot, fd)
  function automatic logic [TW-1:0] tbl_idx(logic [PW-1:0] slot, logic [FW-1:0] fd);
    return TW'(int'(slot) * FDS_PER_PROCESS + int'(fd));
  endfunction

endpackage

// File: hdl/ppdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ppdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/per_process_descriptor_table.sv
// Per-process descriptor table: process scan, descriptor scan, result register.
// Open: accept, process scan over up to NUM_PROCESSES slots, descriptor scan over
//   FDS_PER_PROCESS descriptors, then result; a denied open skips both scans.
// Close: accept, process scan, result; one request in flight at a time.
// Scan length is set by the one-read-per-cycle port of the owner and object RAMs.
// Reset clears valid bits of both tables; RAM contents stay as is.
module per_process_descriptor_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cmd,
  input  logic [ppdt_pkg::PID_W-1:0]    in_proc_id,
  input  logic [ppdt_pkg::OBJ_W-1:0]    in_object_id,
  input  logic [ppdt_pkg::ACCESS_W-1:0] in_access_bits,
  input  logic [ppdt_pkg::MODE_W-1:0]   in_open_mode,
  input  logic [ppdt_pkg::FDNUM_W-1:0]  in_desc_num,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_status,
  output logic [ppdt_pkg::DOUT_W-1:0]   out_desc_out
);

  localparam int NP  = ppdt_pkg::NUM_PROCESSES;
  localparam int FDS = ppdt_pkg::FDS_PER_PROCESS;
  localparam int TD  = ppdt_pkg::TABLE_DEPTH;
  localparam int PW  = ppdt_pkg::PW;
  localparam int FW  = ppdt_pkg::FW;
  localparam int TW  = ppdt_pkg::TW;
  localparam int SCW = ppdt_pkg::SCW;

  // Control state
  ppdt_pkg::state_t state_r, state_nxt;
  logic [NP-1:0]    proc_used_r, proc_used_nxt;
  logic [TD-1:0]    desc_open_r, desc_open_nxt;
  logic [SCW-1:0]   cnt_r, cnt_nxt;
  logic             chk_v_r, chk_v_nxt;
  logic             free_v_r, free_v_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Request and result payload
  ppdt_pkg::cmd_t    cmd_r, cmd_nxt;
  logic [ppdt_pkg::PID_W-1:0]   pid_r, pid_nxt;
  logic [ppdt_pkg::OBJ_W-1:0]   obj_r, obj_nxt;
  logic [ppdt_pkg::FDNUM_W-1:0] fdnum_r, fdnum_nxt;
  logic [SCW-2:0]    chk_r, chk_nxt;
  logic [SCW-2:0]    free_r, free_nxt;
  logic [PW-1:0]     slot_r, slot_nxt;
  ppdt_pkg::status_t res_status_r, res_status_nxt;
  logic [FW-1:0]     res_desc_r, res_desc_nxt;
  ppdt_pkg::status_t out_status_r, out_status_nxt;
  logic [ppdt_pkg::DOUT_W-1:0] out_desc_r, out_desc_nxt;

  // RAM ports
  logic                        own_we;
  logic [PW-1:0]               own_waddr, own_raddr;
  logic [ppdt_pkg::PID_W-1:0]  own_rdata;
  logic                        obj_we;
  logic [TW-1:0]               obj_waddr, obj_raddr;
  logic [ppdt_pkg::OBJ_W-1:0]  obj_rdata;

  // Process owner ids, one entry per slot
  ppdt_ram #(.WIDTH(ppdt_pkg::PID_W), .DEPTH(NP)) u_owner_ram (
    .clk   (clk),
    .we    (own_we),
    .waddr (own_waddr),
    .wdata (pid_r),
    .raddr (own_raddr),
    .rdata (own_rdata)
  );

  // Object held by each descriptor
  ppdt_ram #(.WIDTH(ppdt_pkg::OBJ_W), .DEPTH(TD)) u_object_ram (
    .clk   (clk),
    .we    (obj_we),
    .waddr (obj_waddr),
    .wdata (obj_r),
    .raddr (obj_raddr),
    .rdata (obj_rdata)
  );

  // Sequencer: one read issued per cycle, checked in the next cycle
  always_comb begin
    logic [PW-1:0] p;
    logic [PW-1:0] p_sel;
    logic [FW-1:0] d;
    logic [FW-1:0] d_sel;
    logic [TW-1:0] c_idx;
    logic          hit;
    logic          last;

    state_nxt      = state_r;
    proc_used_nxt  = proc_used_r;
    desc_open_nxt  = desc_open_r;
    cnt_nxt        = cnt_r;
    chk_v_nxt      = 1'b0;
    chk_nxt        = cnt_r[SCW-2:0];
    free_v_nxt     = free_v_r;
    free_nxt       = free_r;
    cmd_nxt        = cmd_r;
    pid_nxt        = pid_r;
    obj_nxt        = obj_r;
    fdnum_nxt      = fdnum_r;
    slot_nxt       = slot_r;
    res_status_nxt = res_status_r;
    res_desc_nxt   = res_desc_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    out_desc_nxt   = out_desc_r;
    own_we         = 1'b0;
    own_waddr      = slot_r;
    own_raddr      = cnt_r[PW-1:0];
    obj_we         = 1'b0;
    obj_waddr      = '0;
    obj_raddr      = '0;
    p              = chk_r[PW-1:0];
    p_sel          = free_v_r ? free_r[PW-1:0] : p;
    d              = chk_r[FW-1:0];
    d_sel          = free_v_r ? free_r[FW-1:0] : d;
    c_idx          = ppdt_pkg::tbl_idx(p, FW'(fdnum_r));
    hit            = 1'b0;
    last           = 1'b0;

    unique case (state_r)
      ppdt_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = ppdt_pkg::cmd_t'(in_cmd);
          pid_nxt      = in_proc_id;
          obj_nxt      = in_object_id;
          fdnum_nxt    = in_desc_num;
          cnt_nxt      = '0;
          free_v_nxt   = 1'b0;
          res_desc_nxt = '0;
          if (in_cmd == ppdt_pkg::CMD_OPEN &&
              !ppdt_pkg::permitted(in_open_mode, in_access_bits)) begin
            res_status_nxt = ppdt_pkg::ST_DENIED;
            state_nxt      = ppdt_pkg::S_DONE;
          end else begin
            state_nxt = ppdt_pkg::S_PSCAN;
          end
        end
      end

      ppdt_pkg::S_PSCAN: begin
        if (cnt_r < SCW'(NP)) begin
          cnt_nxt   = cnt_r + 1'b1;
          chk_v_nxt = 1'b1;
        end
        if (chk_v_r) begin
          hit  = proc_used_r[p] && (own_rdata == pid_r);
          last = (p == PW'(NP - 1));
          if (hit) begin
            slot_nxt   = p;
            cnt_nxt    = '0;
            chk_v_nxt  = 1'b0;
            free_v_nxt = 1'b0;
            if (cmd_r == ppdt_pkg::CMD_CLOSE) begin
              // close of a known process resolves here
              state_nxt = ppdt_pkg::S_DONE;
              if (int'(fdnum_r) >= FDS) begin
                res_status_nxt = ppdt_pkg::ST_BAD_FD;
              end else if (!desc_open_r[c_idx]) begin
                res_status_nxt = ppdt_pkg::ST_FD_CLOSED;
              end else begin
                desc_open_nxt[c_idx] = 1'b0;
                res_status_nxt       = ppdt_pkg::ST_OK;
              end
            end else begin
              state_nxt = ppdt_pkg::S_DSCAN;
            end
          end else begin
            if (!proc_used_r[p] && !free_v_r) begin
              free_v_nxt = 1'b1;
              free_nxt   = chk_r;
            end
            if (last) begin
              if (cmd_r == ppdt_pkg::CMD_CLOSE) begin
                res_status_nxt = ppdt_pkg::ST_UNKNOWN_PROC;
                state_nxt      = ppdt_pkg::S_DONE;
              end else if (free_v_r || !proc_used_r[p]) begin
                // register new process in lowest free slot
                proc_used_nxt[p_sel] = 1'b1;
                own_we               = 1'b1;
                own_waddr            = p_sel;
                slot_nxt             = p_sel;
                cnt_nxt              = '0;
                chk_v_nxt            = 1'b0;
                free_v_nxt           = 1'b0;
                state_nxt            = ppdt_pkg::S_DSCAN;
              end else begin
                res_status_nxt = ppdt_pkg::ST_NO_SLOT;
                state_nxt      = ppdt_pkg::S_DONE;
              end
            end
          end
        end
      end

      ppdt_pkg::S_DSCAN: begin
        if (cnt_r < SCW'(FDS)) begin
          obj_raddr = ppdt_pkg::tbl_idx(slot_r, cnt_r[FW-1:0]);
          cnt_nxt   = cnt_r + 1'b1;
          chk_v_nxt = 1'b1;
        end
        if (chk_v_r) begin
          hit  = desc_open_r[ppdt_pkg::tbl_idx(slot_r, d)] && (obj_rdata == obj_r);
          last = (d == FW'(FDS - 1));
          if (hit) begin
            res_status_nxt = ppdt_pkg::ST_ALREADY_OPEN;
            chk_v_nxt      = 1'b0;
            state_nxt      = ppdt_pkg::S_DONE;
          end else begin
            if (!desc_open_r[ppdt_pkg::tbl_idx(slot_r, d)] && !free_v_r) begin
              free_v_nxt = 1'b1;
              free_nxt   = chk_r;
            end
            if (last) begin
              state_nxt = ppdt_pkg::S_DONE;
              if (free_v_r || !desc_open_r[ppdt_pkg::tbl_idx(slot_r, d)]) begin
                // allocate lowest free descriptor
                desc_open_nxt[ppdt_pkg::tbl_idx(slot_r, d_sel)] = 1'b1;
                obj_we         = 1'b1;
                obj_waddr      = ppdt_pkg::tbl_idx(slot_r, d_sel);
                res_status_nxt = ppdt_pkg::ST_OK;
                res_desc_nxt   = d_sel;
              end else begin
                res_status_nxt = ppdt_pkg::ST_NO_SLOT;
              end
            end
          end
        end
      end

      ppdt_pkg::S_DONE: begin
        // load output register once it is free or being drained
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_desc_nxt   = ppdt_pkg::DOUT_W'(res_desc_r);
          state_nxt      = ppdt_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ppdt_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppdt_pkg::S_IDLE;
      proc_used_r <= '0;
      desc_open_r <= '0;
      cnt_r       <= '0;
      chk_v_r     <= 1'b0;
      free_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      proc_used_r <= proc_used_nxt;
      desc_open_r <= desc_open_nxt;
      cnt_r       <= cnt_nxt;
      chk_v_r     <= chk_v_nxt;
      free_v_r    <= free_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    pid_r        <= pid_nxt;
    obj_r        <= obj_nxt;
    fdnum_r      <= fdnum_nxt;
    chk_r        <= chk_nxt;
    free_r       <= free_nxt;
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    res_desc_r   <= res_desc_nxt;
    out_status_r <= out_status_nxt;
    out_desc_r   <= out_desc_nxt;
  end

  assign in_ready     = (state_r == ppdt_pkg::S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_desc_out = out_desc_r;

endmodule

// File: hdl/ppdt_checker.sv
// Port-level checker for the descriptor table, bound to the top level.
`include "per_process_descriptor_table_defines.svh"

module ppdt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [2:0]                  out_status,
  input logic [ppdt_pkg::DOUT_W-1:0] out_desc_out
);

  // status code must be a defined one
  `PPDT_ASSERT_NOW(a_status_range, clk, rst_n, out_valid, out_status <= ppdt_pkg::ST_FD_CLOSED, "status code out of range")

  // only a successful open carries a descriptor
  `PPDT_ASSERT_NOW(a_desc_zero, clk, rst_n, out_valid && out_status != ppdt_pkg::ST_OK && out_status != ppdt_pkg::ST_OK, out_desc_out == '0, "descriptor set on failed transaction")

  // one request at a time: busy right after accepting a transaction
  `PPDT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "new transaction accepted while busy")

  // stalled result holds
  `PPDT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_desc_out), "stalled result changed")

endmodule

bind per_process_descriptor_table ppdt_checker u_ppdt_checker (.*);
